>>> rtl/bom_pkg.sv
// bom_pkg: shared types and constants of the box overlap scorer.
// No dependencies; imported by bom_geom, bom_cordic, bom_aspect and box_overlap_metric.
package bom_pkg;

    localparam int ANGLE_FRAC   = 30;   // angles in quarter turns, 2^30 = pi/2
    localparam int ANGLE_W      = 32;
    localparam int CORDIC_SHIFT = 24;
    localparam int SCORE_BITS   = 18;
    localparam int OUT_DATA_W   = ((SCORE_BITS + 7) / 8) * 8;
    localparam int TABLE_LEN    = 24;

    typedef enum logic [1:0] {
        MODE_IOU  = 2'd0,
        MODE_GIOU = 2'd1,
        MODE_DIOU = 2'd2,
        MODE_CIOU = 2'd3
    } mode_t;

    typedef logic signed [ANGLE_W-1:0] angle_t;

    // atan(2^-i) in quarter turns
    localparam angle_t ATAN_LUT [TABLE_LEN] = '{
        32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
        32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
        32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
        32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
        32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
        32'sd652,       32'sd326,       32'sd163,       32'sd81
    };

    // control that travels with each beat
    typedef struct packed {
        mode_t mode;
        logic  degen;
    } item_ctl_t;

endpackage

>>> rtl/bom_delay.sv
// bom_delay: enable-gated delay line of configurable length (zero allowed).
// No dependencies.
module bom_delay #(
    parameter int W   = 8,
    parameter int LEN = 1
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);
    generate
        if (LEN == 0)
        begin : g_none
            assign q = d;
        end
        else
        begin : g_line
            logic [W-1:0] tap_reg [LEN];
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    for (int i = 0; i < LEN; i++)
                        tap_reg[i] <= '0;
                end
                else if (en)
                begin
                    tap_reg[0] <= d;
                    for (int i = 1; i < LEN; i++)
                        tap_reg[i] <= tap_reg[i-1];
                end
            end
            assign q = tap_reg[LEN-1];
        end
    endgenerate
endmodule

>>> rtl/bom_div.sv
// bom_div: pipelined restoring divider, floor((num << FRAC) / den), one
// quotient bit per stage. Quotient must fit Q_W bits. Depends on nothing.
module bom_div #(
    parameter int NUM_W  = 24,
    parameter int DEN_W  = 24,
    parameter int Q_W    = 17,
    parameter int FRAC   = 16,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [Q_W-1:0]    quo,
    output logic [SIDE_W-1:0] side_out
);
    localparam int RW = (NUM_W + FRAC > DEN_W + Q_W) ? NUM_W + FRAC : DEN_W + Q_W;

    logic [RW-1:0]     rem_s  [Q_W+1];
    logic [DEN_W-1:0]  den_s  [Q_W+1];
    logic [Q_W-1:0]    q_s    [Q_W+1];
    logic [SIDE_W-1:0] side_s [Q_W+1];
    logic              val_s  [Q_W+1];

    always_comb
    begin
        rem_s[0] = RW'(num) << FRAC;
    end
    assign den_s[0]  = den;
    assign q_s[0]    = '0;
    assign side_s[0] = side_in;
    assign val_s[0]  = in_valid;

    generate
        for (genvar s = 0; s < Q_W; s++)
        begin : g_stage
            logic [RW-1:0]     dsh;
            logic [RW:0]       trial;
            logic [RW-1:0]     rem_next, rem_reg;
            logic [Q_W-1:0]    q_next, q_reg;
            logic [DEN_W-1:0]  den_reg;
            logic [SIDE_W-1:0] side_reg;
            logic              val_reg;

            always_comb
            begin
                dsh   = RW'(den_s[s]) << (Q_W - 1 - s);
                trial = {1'b0, rem_s[s]} - {1'b0, dsh};
                rem_next = trial[RW] ? rem_s[s] : trial[RW-1:0];
                q_next   = {q_s[s][Q_W-2:0], ~trial[RW]};
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg  <= rem_next;
                    q_reg    <= q_next;
                    den_reg  <= den_s[s];
                    side_reg <= side_s[s];
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    val_reg <= 1'b0;
                else if (en)
                    val_reg <= val_s[s];
            end

            assign rem_s[s+1]  = rem_reg;
            assign q_s[s+1]    = q_reg;
            assign den_s[s+1]  = den_reg;
            assign side_s[s+1] = side_reg;
            assign val_s[s+1]  = val_reg;
        end
    endgenerate

    assign out_valid = val_s[Q_W];
    assign quo       = q_s[Q_W];
    assign side_out  = side_s[Q_W];
endmodule

>>> rtl/bom_geom.sv
// bom_geom: three-stage box geometry - clamp and extents, products, sums.
// Depends on bom_pkg.
module bom_geom #(
    parameter int C = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [8*C-1:0]        in_data,
    input  bom_pkg::mode_t        mode,
    output logic [C-1:0]          w1,
    output logic [C-1:0]          h1,
    output logic [C-1:0]          w2,
    output logic [C-1:0]          h2,
    output logic                  out_valid,
    output bom_pkg::item_ctl_t    out_ctl,
    output logic [2*C-1:0]        inter,
    output logic [2*C-1:0]        uni,
    output logic [2*C+2:0]        num2,
    output logic [2*C+2:0]        den2
);
    import bom_pkg::*;

    // stage 1: extents
    logic [C-1:0] l1, t1, r1, b1, l2, t2, r2, b2;
    logic [C-1:0] ix0, ix1, iy0, iy1;
    logic [C-1:0] w1_next, h1_next, w2_next, h2_next, iw_next, ih_next, cw_next, ch_next;
    logic [C:0]   sx1, sx2, sy1, sy2, dx_next, dy_next;
    logic [C-1:0] w1_reg, h1_reg, w2_reg, h2_reg, iw_reg, ih_reg, cw_reg, ch_reg;
    logic [C:0]   dx_reg, dy_reg;
    mode_t        mode1_reg;
    logic         v1_reg;

    always_comb
    begin
        l1 = in_data[0*C +: C];
        t1 = in_data[1*C +: C];
        r1 = in_data[2*C +: C];
        b1 = in_data[3*C +: C];
        l2 = in_data[4*C +: C];
        t2 = in_data[5*C +: C];
        r2 = in_data[6*C +: C];
        b2 = in_data[7*C +: C];
        if (r1 < l1) r1 = l1;
        if (b1 < t1) b1 = t1;
        if (r2 < l2) r2 = l2;
        if (b2 < t2) b2 = t2;
        w1_next = r1 - l1;
        h1_next = b1 - t1;
        w2_next = r2 - l2;
        h2_next = b2 - t2;
        ix0 = (l1 > l2) ? l1 : l2;
        ix1 = (r1 < r2) ? r1 : r2;
        iy0 = (t1 > t2) ? t1 : t2;
        iy1 = (b1 < b2) ? b1 : b2;
        iw_next = (ix1 > ix0) ? ix1 - ix0 : '0;
        ih_next = (iy1 > iy0) ? iy1 - iy0 : '0;
        cw_next = ((r1 > r2) ? r1 : r2) - ((l1 < l2) ? l1 : l2);
        ch_next = ((b1 > b2) ? b1 : b2) - ((t1 < t2) ? t1 : t2);
        // doubled centres
        sx1 = {1'b0, l1} + {1'b0, r1};
        sx2 = {1'b0, l2} + {1'b0, r2};
        sy1 = {1'b0, t1} + {1'b0, b1};
        sy2 = {1'b0, t2} + {1'b0, b2};
        dx_next = (sx1 > sx2) ? sx1 - sx2 : sx2 - sx1;
        dy_next = (sy1 > sy2) ? sy1 - sy2 : sy2 - sy1;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w1_reg    <= w1_next;
            h1_reg    <= h1_next;
            w2_reg    <= w2_next;
            h2_reg    <= h2_next;
            iw_reg    <= iw_next;
            ih_reg    <= ih_next;
            cw_reg    <= cw_next;
            ch_reg    <= ch_next;
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            mode1_reg <= mode;
        end
    end

    // stage 2: products
    logic [2*C-1:0] inter_reg, a1_reg, a2_reg, carea_reg, cw2_reg, ch2_reg;
    logic [2*C+1:0] dx2_reg, dy2_reg;
    mode_t          mode2_reg;
    logic           v2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            inter_reg <= iw_reg * ih_reg;
            a1_reg    <= w1_reg * h1_reg;
            a2_reg    <= w2_reg * h2_reg;
            carea_reg <= cw_reg * ch_reg;
            cw2_reg   <= cw_reg * cw_reg;
            ch2_reg   <= ch_reg * ch_reg;
            dx2_reg   <= dx_reg * dx_reg;
            dy2_reg   <= dy_reg * dy_reg;
            mode2_reg <= mode1_reg;
        end
    end

    // stage 3: union, enclosing sums and divider operands
    logic [2*C:0]   uni_full, cdiag;
    logic [2*C-1:0] uni_next, gnum;
    logic [2*C+2:0] dd, num2_next, den2_next;
    logic [2*C-1:0] inter3_reg, uni_reg;
    logic [2*C+2:0] num2_reg, den2_reg;
    item_ctl_t      ctl_reg;
    item_ctl_t      ctl_next;
    logic           v3_reg;

    always_comb
    begin
        uni_full = {1'b0, a1_reg} + {1'b0, a2_reg} - {1'b0, inter_reg};
        uni_next = uni_full[2*C-1:0];       // never above the enclosing area
        gnum     = carea_reg - uni_next;
        cdiag    = {1'b0, cw2_reg} + {1'b0, ch2_reg};
        dd       = {1'b0, dx2_reg} + {1'b0, dy2_reg};
        if (mode2_reg == MODE_GIOU)
        begin
            num2_next = (2*C+3)'(gnum);
            den2_next = (2*C+3)'(carea_reg);
        end
        else
        begin
            num2_next = dd;
            den2_next = {cdiag, 2'b00};
        end
        ctl_next.mode  = mode2_reg;
        ctl_next.degen = (uni_next == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            inter3_reg <= inter_reg;
            uni_reg    <= uni_next;
            num2_reg   <= num2_next;
            den2_reg   <= den2_next;
            ctl_reg    <= ctl_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign w1        = w1_reg;
    assign h1        = h1_reg;
    assign w2        = w2_reg;
    assign h2        = h2_reg;
    assign out_valid = v3_reg;
    assign out_ctl   = ctl_reg;
    assign inter     = inter3_reg;
    assign uni       = uni_reg;
    assign num2      = num2_reg;
    assign den2      = den2_reg;
endmodule

>>> rtl/bom_cordic.sv
// bom_cordic: pipelined vectoring CORDIC, atan2(w, h) in quarter turns.
// Depends on bom_pkg (angle table).
module bom_cordic #(
    parameter int C     = 12,
    parameter int STEPS = 16
) (
    input  logic            clk,
    input  logic            en,
    input  logic [C-1:0]    w,
    input  logic [C-1:0]    h,
    output bom_pkg::angle_t z
);
    import bom_pkg::*;

    localparam int XW = C + CORDIC_SHIFT + 3;

    logic signed [XW-1:0] x_s [STEPS+1];
    logic signed [XW-1:0] y_s [STEPS+1];
    angle_t               z_s [STEPS+1];
    logic                 zw_s [STEPS+1];

    always_comb
    begin
        x_s[0] = signed'(XW'(h) << CORDIC_SHIFT);
        y_s[0] = signed'(XW'(w) << CORDIC_SHIFT);
    end
    assign z_s[0]  = '0;
    assign zw_s[0] = (w == '0);

    generate
        for (genvar i = 0; i < STEPS; i++)
        begin : g_step
            logic signed [XW-1:0] xs, ys, x_next, y_next, x_reg, y_reg;
            angle_t               z_next, z_reg;
            logic                 zw_reg;

            always_comb
            begin
                xs = x_s[i] >>> i;
                ys = y_s[i] >>> i;
                if (!y_s[i][XW-1])
                begin
                    x_next = x_s[i] + ys;
                    y_next = y_s[i] - xs;
                    z_next = z_s[i] + ATAN_LUT[i];
                end
                else
                begin
                    x_next = x_s[i] - ys;
                    y_next = y_s[i] + xs;
                    z_next = z_s[i] - ATAN_LUT[i];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x_reg  <= x_next;
                    y_reg  <= y_next;
                    z_reg  <= z_next;
                    zw_reg <= zw_s[i];
                end
            end

            assign x_s[i+1]  = x_reg;
            assign y_s[i+1]  = y_reg;
            assign z_s[i+1]  = z_reg;
            assign zw_s[i+1] = zw_reg;
        end
    endgenerate

    // zero width: angle 0
    assign z = zw_s[STEPS] ? '0 : z_s[STEPS];
endmodule

>>> rtl/bom_aspect.sv
// bom_aspect: CIoU aspect term v and v^2 from both boxes' extents.
// Depends on bom_pkg and bom_cordic.
module bom_aspect #(
    parameter int C     = 12,
    parameter int F     = 16,
    parameter int STEPS = 16
) (
    input  logic           clk,
    input  logic           en,
    input  logic [C-1:0]   w1,
    input  logic [C-1:0]   h1,
    input  logic [C-1:0]   w2,
    input  logic [C-1:0]   h2,
    output logic [F:0]     v,
    output logic [2*F+1:0] vsq
);
    import bom_pkg::*;

    localparam int SQ_W = 2 * ANGLE_FRAC;

    angle_t z1, z2;

    bom_cordic #(.C(C), .STEPS(STEPS)) u_cordic_ref (
        .clk (clk), .en (en), .w (w1), .h (h1), .z (z1)
    );

    bom_cordic #(.C(C), .STEPS(STEPS)) u_cordic_cand (
        .clk (clk), .en (en), .w (w2), .h (h2), .z (z2)
    );

    logic signed [ANGLE_W:0] diff;
    logic [ANGLE_W:0]        mag;
    logic                    sat_a_reg, sat_b_reg;
    logic [ANGLE_FRAC-1:0]   m_reg;
    logic [SQ_W-1:0]         sq_reg;
    logic [F:0]              v_next, v_reg, v_d_reg;
    logic [2*F+1:0]          vsq_reg;

    always_comb
    begin
        diff = (ANGLE_W+1)'(z1) - (ANGLE_W+1)'(z2);
        mag  = diff[ANGLE_W] ? unsigned'(-diff) : unsigned'(diff);
        // at or past a quarter turn the term caps at 1.0
        v_next = sat_b_reg ? (F+1)'(1) << F : {1'b0, sq_reg[SQ_W-1 -: F]};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sat_a_reg <= |mag[ANGLE_W:ANGLE_FRAC];
            m_reg     <= mag[ANGLE_FRAC-1:0];
            sq_reg    <= m_reg * m_reg;
            sat_b_reg <= sat_a_reg;
            v_reg     <= v_next;
            vsq_reg   <= v_reg * v_reg;
            v_d_reg   <= v_reg;
        end
    end

    assign v   = v_d_reg;
    assign vsq = vsq_reg;
endmodule

>>> rtl/box_overlap_metric.sv
// box_overlap_metric: top level of the IoU / GIoU / DIoU / CIoU scorer.
// Depends on bom_pkg, bom_geom, bom_div, bom_aspect, bom_cordic, bom_delay.
//
//  channel   dir  handshake               payload
//  s_axis    in   s_axis_tvalid/tready    tdata: 8 box coordinates, COORD_BITS each
//  m_axis    out  m_axis_tvalid/tready    tdata: score; tuser: degenerate
//  cfg       in   cfg_we                  cfg_wdata: metric_mode
//
//  One beat in and one beat out per cycle, sustained while m_axis_tready is high.
//  The slower of the IoU divider and the CORDIC branch sets when the alpha
//  divider starts; the other branch is delayed to match.
//  Reset clears the valid bits and metric_mode; no clearing pass.
//  Every stage shares one enable: the pipe moves when the output register is
//  empty or being taken, so a stall holds every beat in place.
module box_overlap_metric #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16,
    parameter int ATAN_STEPS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // config
    input  logic                            cfg_we,
    input  logic [1:0]                      cfg_wdata,   // metric_mode
    // input beats
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // ref_left, ref_top, ref_right, ref_bottom,
    // cand_left, cand_top, cand_right, cand_bottom (lowest first)
    input  logic [8*COORD_BITS-1:0]         s_axis_tdata,
    // result beats
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [bom_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // score, zero pad
    output logic                            m_axis_tuser   // degenerate
);
    import bom_pkg::*;

    localparam int C      = COORD_BITS;
    localparam int F      = FRAC_BITS;
    localparam int Q      = F + 1;            // quotients never exceed 1.0
    localparam int T_MAIN = 3 + Q;            // divider results ready
    localparam int T_ASP  = 5 + ATAN_STEPS;   // v and v^2 ready
    localparam int T_ALN  = (T_MAIN > T_ASP) ? T_MAIN : T_ASP;
    localparam int MAIN_W = 1 + $bits(item_ctl_t) + 2 * Q;
    localparam int ASP_W  = (F + 1) + (2 * F + 2);
    localparam int SIDE_W = $bits(item_ctl_t) + 2 * Q + 1;
    localparam int SW     = F + 3;
    localparam int EW     = (SW > SCORE_BITS) ? SW : SCORE_BITS;

    logic en;
    logic out_valid_reg;
    logic [SCORE_BITS-1:0] score_reg;
    logic degen_reg;
    mode_t mode_reg;

    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_IOU;
        else if (cfg_we)
            mode_reg <= mode_t'(cfg_wdata);
    end

    // geometry: three stages
    logic [C-1:0]   w1, h1, w2, h2;
    logic           g_valid;
    item_ctl_t      g_ctl;
    logic [2*C-1:0] inter, uni;
    logic [2*C+2:0] num2, den2;

    bom_geom #(.C(C)) u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid && s_axis_tready),
        .in_data   (s_axis_tdata),
        .mode      (mode_reg),
        .w1        (w1),
        .h1        (h1),
        .w2        (w2),
        .h2        (h2),
        .out_valid (g_valid),
        .out_ctl   (g_ctl),
        .inter     (inter),
        .uni       (uni),
        .num2      (num2),
        .den2      (den2)
    );

    // IoU divider, carries valid and control
    logic         d1_valid;
    logic [Q-1:0] iou;
    item_ctl_t    d1_ctl;

    bom_div #(.NUM_W(2*C), .DEN_W(2*C), .Q_W(Q), .FRAC(F),
              .SIDE_W($bits(item_ctl_t))) u_div_iou (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (g_valid),
        .num       (inter),
        .den       (uni),
        .side_in   (g_ctl),
        .out_valid (d1_valid),
        .quo       (iou),
        .side_out  (d1_ctl)
    );

    // GIoU empty share or DIoU/CIoU distance term, selected upstream by mode
    logic [Q-1:0] pen;

    bom_div #(.NUM_W(2*C+3), .DEN_W(2*C+3), .Q_W(Q), .FRAC(F),
              .SIDE_W(1)) u_div_pen (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (g_valid),
        .num       (num2),
        .den       (den2),
        .side_in   (1'b0),
        .out_valid (),
        .quo       (pen),
        .side_out  ()
    );

    // CIoU aspect term, starts from the stage-1 extents
    logic [F:0]     v;
    logic [2*F+1:0] vsq;

    bom_aspect #(.C(C), .F(F), .STEPS(ATAN_STEPS)) u_aspect (
        .clk (clk),
        .en  (en),
        .w1  (w1),
        .h1  (h1),
        .w2  (w2),
        .h2  (h2),
        .v   (v),
        .vsq (vsq)
    );

    // bring both branches to the same cycle
    logic [MAIN_W-1:0] main_q;
    logic [ASP_W-1:0]  asp_q;

    bom_delay #(.W(MAIN_W), .LEN(T_ALN - T_MAIN)) u_dly_main (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .d     ({d1_valid, d1_ctl, iou, pen}),
        .q     (main_q)
    );

    bom_delay #(.W(ASP_W), .LEN(T_ALN - T_ASP)) u_dly_asp (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .d     ({v, vsq}),
        .q     (asp_q)
    );

    logic           a_valid;
    item_ctl_t      a_ctl;
    logic [Q-1:0]   a_iou, a_pen;
    logic [F:0]     a_v;
    logic [2*F+1:0] a_vsq;

    assign {a_valid, a_ctl, a_iou, a_pen} = main_q;
    assign {a_v, a_vsq} = asp_q;

    // alpha denominator: 1.0 - IoU + v
    logic [F+1:0]   p_den_reg;
    logic [2*F+1:0] p_num_reg;
    logic [SIDE_W-1:0] p_side_reg;
    logic           p_valid_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_den_reg  <= ((F+2)'(1) << F) - (F+2)'(a_iou) + (F+2)'(a_v);
            p_num_reg  <= a_vsq;
            p_side_reg <= {a_ctl, a_iou, a_pen, (a_v != '0)};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_valid_reg <= 1'b0;
        else if (en)
            p_valid_reg <= a_valid;
    end

    logic              al_valid;
    logic [Q-1:0]      alpha_v;
    logic [SIDE_W-1:0] al_side;

    // v^2 / den, FRAC of zero: 2F fraction bits over F gives the score scale
    bom_div #(.NUM_W(2*F+2), .DEN_W(F+2), .Q_W(Q), .FRAC(0),
              .SIDE_W(SIDE_W)) u_div_alpha (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (p_valid_reg),
        .num       (p_num_reg),
        .den       (p_den_reg),
        .side_in   (p_side_reg),
        .out_valid (al_valid),
        .quo       (alpha_v),
        .side_out  (al_side)
    );

    // final combine and limit to [-2.0, 1.0]
    item_ctl_t            f_ctl;
    logic [Q-1:0]         f_iou, f_pen;
    logic                 f_vnz;
    logic signed [SW-1:0] sc, s_one, s_mtwo;
    logic signed [EW-1:0] sc_ext;

    always_comb
    begin
        {f_ctl, f_iou, f_pen, f_vnz} = al_side;
        s_one  = signed'(SW'(1) << F);
        s_mtwo = -(s_one <<< 1);
        sc = signed'(SW'(f_iou));
        if (f_ctl.mode != MODE_IOU)
            sc = sc - signed'(SW'(f_pen));
        if (f_ctl.mode == MODE_CIOU && f_vnz)
            sc = sc - signed'(SW'(alpha_v));
        if (sc > s_one)
            sc = s_one;
        if (sc < s_mtwo)
            sc = s_mtwo;
        if (f_ctl.degen)
            sc = '0;
        sc_ext = EW'(sc);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            score_reg <= sc_ext[SCORE_BITS-1:0];
            degen_reg <= f_ctl.degen;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= al_valid;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'(score_reg);
    assign m_axis_tuser  = degen_reg;

    // a degenerate beat always carries a zero score
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> score_reg == '0)
        else $error("degenerate beat with non-zero score");

    // a stall freezes the alpha stage
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(p_valid_reg) && $stable(p_side_reg))
        else $error("pipeline moved during stall");

    // output valid follows the last divider stage whenever the pipe moves
    a_out_follow: assert property (@(posedge clk) disable iff (!rst_n)
        en |=> out_valid_reg == $past(al_valid))
        else $error("output valid lost or invented");
endmodule
